>>> rtl/core/atsr_pkg.sv
`timescale 1ns / 1ps

package atsr_pkg;

	localparam int DISPLAY_BYTES = 6912;
	localparam int ADDR_W = $clog2(DISPLAY_BYTES);
	localparam logic [ADDR_W-1:0] ATTR_BASE = ADDR_W'(13'h1800);

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_RENDER = 2'd1,
		MODE_FRAME  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ATTR,
		ST_BITS,
		ST_EMIT
	} state_t;

	// Fixed sixteen-colour palette: normal levels 0xD8, bright levels 0xFF.
	function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
		logic [7:0] lvl;
		lvl = idx[3] ? 8'hFF : 8'hD8;
		palette_rgb = {idx[1] ? lvl : 8'h00, idx[2] ? lvl : 8'h00, idx[0] ? lvl : 8'h00};
	endfunction

	// Interleaved bitmap offset of a character column and pixel line.
	function automatic logic [ADDR_W-1:0] pixel_offset(input logic [4:0] col,
		input logic [7:0] line);
		pixel_offset = ADDR_W'({line[7:6], line[2:0], line[5:3], col});
	endfunction

	// Attribute offset: one byte for each eight-line character cell.
	function automatic logic [ADDR_W-1:0] attr_offset(input logic [4:0] col,
		input logic [7:0] line);
		attr_offset = ATTR_BASE + ADDR_W'({line[7:3], col});
	endfunction

endpackage

>>> rtl/core/attribute_screen_renderer.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Beat content
// input    in         in_valid / in_ready   mode, address, data, column, row
// output   out        out_valid / out_ready colour_index, red, green, blue, last_pixel
//
// A write or end-of-frame beat leaves the state machine idle; the block is ready
// again at the next edge. A render beat is followed by store access (attribute
// read, bitmap read, pixel setup) on the single store read port, then
// eight output beats. An output stall holds the current pixel until out_ready
// is high. Reset clears the state machine and the frame count; the display
// store itself is not cleared.
module attribute_screen_renderer
	import atsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [12:0] address,
	input  logic [7:0]  data,
	input  logic [4:0]  column,
	input  logic [7:0]  row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  colour_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_pixel
);

	// The display store: one write port and one registered read port.
	logic [7:0] store_mem [0:DISPLAY_BYTES-1];

	state_t            state_q, state_d;
	logic [4:0]        frame_q;
	logic [4:0]        col_q;
	logic [7:0]        row_q;
	logic [7:0]        rdata_q;
	logic              oob_q;
	logic [7:0]        rbyte;
	logic [2:0]        ink_q, paper_q;
	logic              bright_q;
	logic [7:0]        bits_q;
	logic [2:0]        cnt_q;
	logic              in_fire, out_fire;
	logic              wr_en;
	logic [ADDR_W-1:0] raddr;
	logic              raddr_oob;
	logic [23:0]       rgb;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Writes beyond the end of the store are dropped.
	assign wr_en = in_fire && (mode_t'(mode) == MODE_WRITE)
		&& (address < ADDR_W'(DISPLAY_BYTES));

	// In idle the read port looks up the attribute of the incoming cell; in the
	// other states it looks up the bitmap byte of the captured cell.
	always_comb begin
		if (state_q == ST_IDLE) begin
			raddr = attr_offset(column, row);
		end else begin
			raddr = pixel_offset(col_q, row_q);
		end
	end

	assign raddr_oob = (raddr >= ADDR_W'(DISPLAY_BYTES));

	// Offsets past the store read as zero.
	assign rbyte = oob_q ? 8'h00 : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[address] <= data;
		end
		if (!raddr_oob) begin
			rdata_q <= store_mem[raddr];
		end
		oob_q <= raddr_oob;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			frame_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire && (mode_t'(mode) == MODE_FRAME)) begin
				frame_q <= frame_q + 5'd1;
			end
			if (state_q == ST_BITS) begin
				cnt_q <= '0;
			end else if (out_fire) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// Payload registers of the cell being rendered.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_q <= column;
			row_q <= row;
		end
		if (state_q == ST_ATTR) begin
			// Flash swaps ink and paper during frames 16 to 31 of every 32.
			bright_q <= rbyte[6];
			if (rbyte[7] && frame_q[4]) begin
				ink_q   <= rbyte[5:3];
				paper_q <= rbyte[2:0];
			end else begin
				ink_q   <= rbyte[2:0];
				paper_q <= rbyte[5:3];
			end
		end
		if (state_q == ST_BITS) begin
			bits_q <= rbyte;
		end else if (out_fire) begin
			bits_q <= {bits_q[6:0], 1'b0};
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (mode_t'(mode) == MODE_RENDER)) begin
					state_d = ST_ATTR;
				end
			end
			ST_ATTR: begin
				state_d = ST_BITS;
			end
			ST_BITS: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && (cnt_q == 3'd7)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The leftmost remaining pixel sits in the top bit of the shift register.
	assign colour_index = {bright_q, bits_q[7] ? ink_q : paper_q};
	assign rgb          = palette_rgb(colour_index);
	assign red          = rgb[23:16];
	assign green        = rgb[15:8];
	assign blue         = rgb[7:0];
	assign last_pixel   = (cnt_q == 3'd7);

endmodule

>>> rtl/core/atsr_checker.sv
`timescale 1ns / 1ps

module atsr_checker
	import atsr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  colour_index,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic        last_pixel
);

	// The block works on one item at a time, so it never takes input while
	// pixels are pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while pixels are pending");

	// An item that gives no pixels leaves the block ready at once.
	a_quiet_items: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (mode != MODE_RENDER)) |=> in_ready)
		else $error("non-render item did not return to ready");

	// After the rightmost pixel the cell is finished.
	a_cell_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_pixel) |=> (!out_valid && in_ready))
		else $error("output continued after the last pixel");

	// Colour components always match the palette entry of the index.
	a_palette: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({red, green, blue} == palette_rgb(colour_index)))
		else $error("colour components disagree with palette index");

	// A stalled pixel holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(colour_index)
			&& $stable(last_pixel)))
		else $error("stalled pixel changed");

endmodule

bind attribute_screen_renderer atsr_checker u_atsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.mode         (mode),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.colour_index (colour_index),
	.red          (red),
	.green        (green),
	.blue         (blue),
	.last_pixel   (last_pixel)
);
